### hdl/nps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package nps_pkg;

  localparam int SLOTS      = 16;
  localparam int BURST_BITS = 16;
  localparam int IDX_W      = $clog2(SLOTS);
  localparam int CNT_W      = $clog2(SLOTS + 1);
  localparam int ENTRY_W    = 4 + 8 + BURST_BITS;

  localparam logic OP_ARRIVE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  typedef enum logic [1:0] {
    ST_RAN     = 2'd0,
    ST_IDLE    = 2'd1,
    ST_QUEUED  = 2'd2,
    ST_REFUSED = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_WAIT,
    S_SCAN,
    S_FETCH,
    S_RUN,
    S_SHIFT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [3:0]            id;
    logic [7:0]            prio;
    logic [BURST_BITS-1:0] left;
  } entry_t;

  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [ENTRY_W-1:0] wdata;
    logic [IDX_W-1:0]   raddr;
  } ram_req_t;

  typedef struct packed {
    status_t     status;
    logic [3:0]  running_id;
    logic        finished;
    logic [31:0] time_now;
  } result_t;

endpackage

`default_nettype wire

### hdl/nps_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface nps_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [3:0]  process_id;
  logic [7:0]  priority_req;
  logic [15:0] burst;

  modport source (output valid, op, process_id, priority_req, burst, input ready);
  modport sink   (input valid, op, process_id, priority_req, burst, output ready);
endinterface

interface nps_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [3:0]  running_id;
  logic        finished;
  logic [31:0] time_now;

  modport source (output valid, status, running_id, finished, time_now, input ready);
  modport sink   (input valid, status, running_id, finished, time_now, output ready);
endinterface

`default_nettype wire

### hdl/nps_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module nps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hdl/nps_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module nps_ctrl
  import nps_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  nps_in_if.sink                  in_ch,
  output ram_req_t                ram_req,
  input  wire logic [ENTRY_W-1:0] ram_rdata,
  output result_t                 res,
  output logic                    res_valid,
  input  wire logic               res_take
);

  state_t                state, state_next;
  logic [CNT_W-1:0]      count, count_next;
  logic                  busy, busy_next;
  logic [IDX_W-1:0]      run_slot, run_slot_next;
  logic [31:0]           cur_time, cur_time_next;
  logic [IDX_W-1:0]      scan_idx, scan_idx_next;
  logic [IDX_W-1:0]      best_slot, best_slot_next;
  logic [7:0]            best_prio, best_prio_next;
  logic [IDX_W-1:0]      sh_idx, sh_idx_next;
  result_t               res_next;
  entry_t                rd_entry;
  logic [31:0]           burst_wide;
  logic [BURST_BITS-1:0] burst_eff;
  logic [BURST_BITS-1:0] left_new;
  logic [IDX_W-1:0]      pick;

  assign rd_entry   = entry_t'(ram_rdata);
  assign burst_wide = 32'(in_ch.burst);
  assign burst_eff  = burst_wide[BURST_BITS-1:0];
  assign left_new   = rd_entry.left - BURST_BITS'(1);

  assign in_ch.ready = (state == S_WAIT);
  assign res_valid   = (state == S_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_WAIT;
      count    <= '0;
      busy     <= 1'b0;
      run_slot <= '0;
      cur_time <= '0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      busy     <= busy_next;
      run_slot <= run_slot_next;
      cur_time <= cur_time_next;
    end
    scan_idx  <= scan_idx_next;
    best_slot <= best_slot_next;
    best_prio <= best_prio_next;
    sh_idx    <= sh_idx_next;
    res       <= res_next;
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    busy_next      = busy;
    run_slot_next  = run_slot;
    cur_time_next  = cur_time;
    scan_idx_next  = scan_idx;
    best_slot_next = best_slot;
    best_prio_next = best_prio;
    sh_idx_next    = sh_idx;
    res_next       = res;
    pick           = best_slot;
    ram_req.we     = 1'b0;
    ram_req.waddr  = run_slot;
    ram_req.wdata  = ram_rdata;
    ram_req.raddr  = '0;

    case (state)
      S_WAIT: begin
        ram_req.raddr = busy ? run_slot : '0;
        if (in_ch.valid) begin
          if (in_ch.op == OP_ARRIVE) begin
            if (burst_eff == '0 || count == CNT_W'(SLOTS)) begin
              res_next = '{ST_REFUSED, 4'd0, 1'b0, cur_time};
            end else begin
              ram_req.we    = 1'b1;
              ram_req.waddr = count[IDX_W-1:0];
              ram_req.wdata = {in_ch.process_id, in_ch.priority_req, burst_eff};
              count_next    = count + CNT_W'(1);
              res_next      = '{ST_QUEUED, 4'd0, 1'b0, cur_time};
            end
            state_next = S_DONE;
          end else begin
            cur_time_next = cur_time + 32'd1;
            if (busy) begin
              state_next = S_RUN;
            end else if (count == '0) begin
              res_next   = '{ST_IDLE, 4'd0, 1'b0, cur_time + 32'd1};
              state_next = S_DONE;
            end else begin
              scan_idx_next = '0;
              state_next    = S_SCAN;
            end
          end
        end
      end

      S_SCAN: begin
        ram_req.raddr = IDX_W'({1'b0, scan_idx} + (IDX_W + 1)'(1));
        if (scan_idx == '0 || rd_entry.prio < best_prio) begin
          best_prio_next = rd_entry.prio;
          best_slot_next = scan_idx;
          pick           = scan_idx;
        end
        if (CNT_W'(scan_idx) + CNT_W'(1) == count) begin
          busy_next     = 1'b1;
          run_slot_next = pick;
          state_next    = S_FETCH;
        end else begin
          scan_idx_next = scan_idx + IDX_W'(1);
        end
      end

      S_FETCH: begin
        ram_req.raddr = run_slot;
        state_next    = S_RUN;
      end

      S_RUN: begin
        ram_req.raddr = IDX_W'({1'b0, run_slot} + (IDX_W + 1)'(1));
        res_next = '{ST_RAN, rd_entry.id, (left_new == '0), cur_time};
        if (left_new == '0) begin
          busy_next     = 1'b0;
          run_slot_next = '0;
          count_next    = count - CNT_W'(1);
          if (CNT_W'(run_slot) + CNT_W'(1) < count) begin
            sh_idx_next = run_slot;
            state_next  = S_SHIFT;
          end else begin
            state_next = S_DONE;
          end
        end else begin
          ram_req.we    = 1'b1;
          ram_req.waddr = run_slot;
          ram_req.wdata = {rd_entry.id, rd_entry.prio, left_new};
          state_next    = S_DONE;
        end
      end

      S_SHIFT: begin
        ram_req.raddr = IDX_W'({1'b0, sh_idx} + (IDX_W + 1)'(2));
        ram_req.we    = 1'b1;
        ram_req.waddr = sh_idx;
        ram_req.wdata = ram_rdata;
        if (CNT_W'(sh_idx) + CNT_W'(1) == count) begin
          state_next = S_DONE;
        end else begin
          sh_idx_next = sh_idx + IDX_W'(1);
        end
      end

      S_DONE: begin
        if (res_take) begin
          state_next = S_WAIT;
        end
      end

      default: begin
        state_next = S_WAIT;
      end
    endcase
  end

endmodule

`default_nettype wire

### hdl/nonpreemptive_priority_scheduler_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// channel | dir | word                                          | handshake
// in_ch   | in  | op, process_id, priority_req, burst            | valid/ready
// out_ch  | out | status, running_id, finished, time_now        | valid/ready
//
// one item at a time; arrival and idle tick go through S_DONE to the output register
// tick on a running job: ready list ram read, update, result
// tick that selects a job: one ram read per queued entry, then fetch, run, result
// a finishing job shifts each later entry down one slot to close the gap in the ram
// synchronous reset empties the list and clears time; no clearing pass
// a result waiting in the output register does not block the next word, only the next result

module nonpreemptive_priority_scheduler_unit
  import nps_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  nps_in_if.sink    in_ch,
  nps_out_if.source out_ch
);

  ram_req_t         ram_req;
  logic [ENTRY_W-1:0] ram_rdata;
  result_t          res;
  logic             res_valid;
  logic             res_take;
  logic             out_valid;
  result_t          out_word;

  nps_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(SLOTS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_req.we),
    .waddr(ram_req.waddr),
    .wdata(ram_req.wdata),
    .raddr(ram_req.raddr),
    .rdata(ram_rdata)
  );

  nps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .ram_req  (ram_req),
    .ram_rdata(ram_rdata),
    .res      (res),
    .res_valid(res_valid),
    .res_take (res_take)
  );

  assign res_take = res_valid && (!out_valid || out_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
    if (res_take) begin
      out_word <= res;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.status     = out_word.status;
  assign out_ch.running_id = out_word.running_id;
  assign out_ch.finished   = out_word.finished;
  assign out_ch.time_now   = out_word.time_now;

endmodule

`default_nettype wire

### hdl/nps_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module nps_checker
  import nps_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  status,
  input wire logic [3:0]  running_id,
  input wire logic        finished,
  input wire logic [31:0] time_now
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word shown right after reset");

  a_finish_ran: assert property (@(posedge clk) disable iff (rst)
    out_valid && finished |-> status == ST_RAN)
    else $error("finish flag on a word that ran no job");

  a_non_run_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_RAN |-> running_id == 4'd0 && !finished)
    else $error("job id or finish flag on a non-running word");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(running_id)
      && $stable(finished) && $stable(time_now))
    else $error("stalled result word changed");

endmodule

bind nonpreemptive_priority_scheduler_unit nps_checker u_nps_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .status    (out_ch.status),
  .running_id(out_ch.running_id),
  .finished  (out_ch.finished),
  .time_now  (out_ch.time_now)
);

`default_nettype wire
